// ===== hdl/rlss_pkg.sv =====
`default_nettype none

package rlss_pkg;

   localparam int MAX_LEDS_DEF   = 64;
   localparam int BPP_DEF        = 24;
   localparam int PIX_W          = 24;
   localparam int COLOR_W        = 8;
   localparam int IDX_FIELD_W    = 6;
   localparam int LED_COUNT_W    = 7;
   localparam int DUTY_W         = 8;
   localparam int SLOT_W         = 8;
   localparam int REQ_TYPE_W     = 2;
   localparam int CSR_ADDR_W     = 4;
   localparam int CSR_DATA_W     = 32;
   localparam int REQ_TDATA_W    = 32;
   localparam int RSP_TDATA_W    = 16;

   localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST   = 7'd64;
   localparam logic [DUTY_W-1:0]      ONE_DUTY_RST    = 8'd67;
   localparam logic [DUTY_W-1:0]      ZERO_DUTY_RST   = 8'd34;
   localparam logic [SLOT_W-1:0]      RESET_SLOTS_RST = 8'd48;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_WRITE = 2'd0,
      REQ_FILL  = 2'd1,
      REQ_START = 2'd2,
      REQ_TICK  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      REG_LED_COUNT   = 2'd0,
      REG_ONE_DUTY    = 2'd1,
      REG_ZERO_DUTY   = 2'd2,
      REG_RESET_SLOTS = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'b0001,
      PH_RST_START = 4'b0010,
      PH_DATA      = 4'b0100,
      PH_RST_END   = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } ctrl_state_type;

   typedef struct packed {
      logic [LED_COUNT_W-1:0] led_count;
      logic [DUTY_W-1:0]      one_duty;
      logic [DUTY_W-1:0]      zero_duty;
      logic [SLOT_W-1:0]      reset_slots;
   } cfg_type;

   typedef struct packed {
      logic                   wr_en;
      logic                   fill_en;
      logic [IDX_FIELD_W-1:0] addr;
      logic [PIX_W-1:0]       pixel;
   } mem_cmd_type;

   function automatic logic [PIX_W-1:0] pack_grb(input logic [COLOR_W-1:0] r,
                                                  input logic [COLOR_W-1:0] g,
                                                  input logic [COLOR_W-1:0] b);
      return {g, r, b};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/rlss_csr.sv =====
`default_nettype none

module rlss_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [rlss_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rlss_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [rlss_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready,
   output rlss_pkg::cfg_type                  cfg
);
   import rlss_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type reg_sel;
   logic          wr_en;

   assign reg_sel    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.led_count   <= LED_COUNT_RST;
         cfg_ff.one_duty    <= ONE_DUTY_RST;
         cfg_ff.zero_duty   <= ZERO_DUTY_RST;
         cfg_ff.reset_slots <= RESET_SLOTS_RST;
      end else if (wr_en) begin
         case (reg_sel)
            REG_LED_COUNT:   cfg_ff.led_count   <= csr_pwdata[LED_COUNT_W-1:0];
            REG_ONE_DUTY:    cfg_ff.one_duty    <= csr_pwdata[DUTY_W-1:0];
            REG_ZERO_DUTY:   cfg_ff.zero_duty   <= csr_pwdata[DUTY_W-1:0];
            REG_RESET_SLOTS: cfg_ff.reset_slots <= csr_pwdata[SLOT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_LED_COUNT:   csr_prdata = CSR_DATA_W'(cfg_ff.led_count);
         REG_ONE_DUTY:    csr_prdata = CSR_DATA_W'(cfg_ff.one_duty);
         REG_ZERO_DUTY:   csr_prdata = CSR_DATA_W'(cfg_ff.zero_duty);
         REG_RESET_SLOTS: csr_prdata = CSR_DATA_W'(cfg_ff.reset_slots);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/rlss_pixel_mem.sv =====
`default_nettype none

module rlss_pixel_mem #(
   parameter int MAX_LEDS = rlss_pkg::MAX_LEDS_DEF,
   parameter int IDX_W    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [IDX_W-1:0]         rd_addr,
   input  wire rlss_pkg::mem_cmd_type    cmd,
   output logic [rlss_pkg::PIX_W-1:0]    rd_pixel
);
   import rlss_pkg::*;

   logic [PIX_W-1:0]    mem [MAX_LEDS];
   logic [MAX_LEDS-1:0] valid_ff;
   logic [PIX_W-1:0]    fill_ff;
   logic [PIX_W-1:0]    rd_data_ff;
   logic                rd_valid_ff;
   logic [IDX_W-1:0]    wr_addr;

   assign wr_addr = IDX_W'(cmd.addr);

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= cmd.pixel;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // A fill drops every valid bit, so each entry falls back to the fill color
   // until it is written again. Reset does the same with a black fill color.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= '0;
      end else if (cmd.fill_en) begin
         valid_ff <= '0;
         fill_ff  <= cmd.pixel;
      end else if (cmd.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_pixel = rd_valid_ff ? rd_data_ff : fill_ff;

endmodule

`default_nettype wire

// ===== hdl/rgb_led_strip_serializer.sv =====
// RGB LED strip serializer.
// Requests enter on the req_ channel: req_tuser carries the request kind
// (write one pixel, fill all pixels, start a refresh, bit-period tick) and
// req_tdata carries the pixel index and the color. Every request gives one
// item on the rsp_ channel with the PWM compare value for that tick, the
// line-active flag and the ok flag; rsp_tlast marks the last slot of a frame.
// The four registers (LED count, one and zero duty, reset pulse length) sit
// on the csr_ port. The user writes them while no request is in flight;
// the block itself does not enforce this. An accepted request is registered
// and waits in the execute step, which commits its result to the output
// register on rsp_ once that register is free. No new request is taken
// until the last one has left the execute step. The output register holds a
// result while the receiver stalls, and the next request is taken meanwhile.
// Reset makes all pixels black at once, stops any refresh and restores the
// register defaults; requests are accepted as soon as reset is released.
`default_nettype none

module rgb_led_strip_serializer #(
   parameter int MAX_LEDS       = rlss_pkg::MAX_LEDS_DEF,
   parameter int BITS_PER_PIXEL = rlss_pkg::BPP_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // led_index[5:0], red[13:6], green[21:14], blue[29:22], zero fill
   input  wire logic [rlss_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  wire logic [rlss_pkg::REQ_TYPE_W-1:0]  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // duty[7:0], line_active[8], ok[9], zero fill
   output logic      [rlss_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                                 rsp_tlast,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rlss_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [rlss_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [rlss_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import rlss_pkg::*;

   localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int PP_W  = $clog2(MAX_LEDS + 1);
   localparam int CMP_W = (PP_W > LED_COUNT_W) ? PP_W : LED_COUNT_W;
   localparam int BP_W  = $clog2(BITS_PER_PIXEL);

   cfg_type        cfg;
   mem_cmd_type    cmd;
   logic [PIX_W-1:0] rd_pixel;

   ctrl_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic [SLOT_W-1:0] slot_ff, slot_in, slot_inc;
   logic [PP_W-1:0]   pp_ff, pp_in, pp_inc;
   logic [BP_W-1:0]   bp_ff, bp_in;

   req_kind_type           kind_ff;
   logic [IDX_FIELD_W-1:0] idx_ff;
   logic [COLOR_W-1:0]     red_ff, green_ff, blue_ff;

   logic                   rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic                   rsp_tlast_ff;

   logic              go;
   logic [CMP_W-1:0]  eff_count;
   logic [SLOT_W-1:0] eff_reset;
   logic [4:0]        pix_pos;
   logic              pix_bit;
   logic [DUTY_W-1:0] res_duty;
   logic              res_active, res_ok, res_done;

   rlss_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg)
   );

   rlss_pixel_mem #(
      .MAX_LEDS(MAX_LEDS),
      .IDX_W   (IDX_W)
   ) u_pixel_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (pp_ff[IDX_W-1:0]),
      .cmd     (cmd),
      .rd_pixel(rd_pixel)
   );

   // Out-of-range counts are clamped to one and to the store depth.
   always_comb begin
      if (cfg.led_count == '0) begin
         eff_count = CMP_W'(1);
      end else if (CMP_W'(cfg.led_count) > CMP_W'(MAX_LEDS)) begin
         eff_count = CMP_W'(MAX_LEDS);
      end else begin
         eff_count = CMP_W'(cfg.led_count);
      end
   end

   assign eff_reset = (cfg.reset_slots == '0) ? SLOT_W'(1) : cfg.reset_slots;

   assign req_tready = (state_ff == ST_IDLE);
   assign go = (state_ff == ST_EXEC) && (!rsp_tvalid_ff || rsp_tready);

   // Wide pixels send the 24-bit color first and pad with zero bits.
   assign pix_pos = 5'(PIX_W - 1) - 5'(bp_ff);
   assign pix_bit = (5'(bp_ff) < 5'(PIX_W)) ? rd_pixel[pix_pos] : 1'b0;

   assign slot_inc = slot_ff + SLOT_W'(1);
   assign pp_inc   = pp_ff + PP_W'(1);

   always_comb begin
      phase_in = phase_ff;
      slot_in  = slot_ff;
      pp_in    = pp_ff;
      bp_in    = bp_ff;
      res_duty = '0;
      res_ok   = 1'b1;
      res_done = 1'b0;
      cmd      = '0;
      case (kind_ff)
         REQ_WRITE: begin
            if (CMP_W'(idx_ff) < eff_count) begin
               cmd.wr_en = go;
               cmd.addr  = idx_ff;
               cmd.pixel = pack_grb(red_ff, green_ff, blue_ff);
            end else begin
               res_ok = 1'b0;
            end
         end
         REQ_FILL: begin
            cmd.fill_en = go;
            cmd.pixel   = pack_grb(red_ff, green_ff, blue_ff);
         end
         REQ_START: begin
            if (phase_ff != PH_IDLE) begin
               res_ok = 1'b0;
            end else begin
               phase_in = PH_RST_START;
               slot_in  = '0;
               pp_in    = '0;
               bp_in    = '0;
            end
         end
         REQ_TICK: begin
            case (phase_ff)
               PH_RST_START: begin
                  slot_in = slot_inc;
                  if (slot_inc >= eff_reset) begin
                     phase_in = PH_DATA;
                     slot_in  = '0;
                     pp_in    = '0;
                     bp_in    = '0;
                  end
               end
               PH_DATA: begin
                  if (CMP_W'(pp_ff) >= eff_count) begin
                     // The count dropped under the pointer: this tick is
                     // already the first slot of the closing pulse.
                     if (eff_reset == SLOT_W'(1)) begin
                        phase_in = PH_IDLE;
                        slot_in  = '0;
                        res_done = 1'b1;
                     end else begin
                        phase_in = PH_RST_END;
                        slot_in  = SLOT_W'(1);
                     end
                  end else begin
                     res_duty = pix_bit ? cfg.one_duty : cfg.zero_duty;
                     if (bp_ff == BP_W'(BITS_PER_PIXEL - 1)) begin
                        bp_in = '0;
                        pp_in = pp_inc;
                        if (CMP_W'(pp_inc) >= eff_count) begin
                           phase_in = PH_RST_END;
                           slot_in  = '0;
                        end
                     end else begin
                        bp_in = bp_ff + BP_W'(1);
                     end
                  end
               end
               PH_RST_END: begin
                  slot_in = slot_inc;
                  if (slot_inc >= eff_reset) begin
                     phase_in = PH_IDLE;
                     slot_in  = '0;
                     res_done = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      res_active = (kind_ff == REQ_TICK) ? (phase_ff != PH_IDLE) : (phase_in != PH_IDLE);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_IDLE;
         slot_ff       <= '0;
         pp_ff         <= '0;
         bp_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (go) begin
            phase_ff      <= phase_in;
            slot_ff       <= slot_in;
            pp_ff         <= pp_in;
            bp_ff         <= bp_in;
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff  <= req_kind_type'(req_tuser);
         idx_ff   <= req_tdata[5:0];
         red_ff   <= req_tdata[13:6];
         green_ff <= req_tdata[21:14];
         blue_ff  <= req_tdata[29:22];
      end
      if (go) begin
         rsp_tdata_ff <= {6'b0, res_ok, res_active, res_duty};
         rsp_tlast_ff <= res_done;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   a_done_while_active: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tlast_ff |-> rsp_tdata_ff[8])
      else $error("frame end reported outside a refresh");

   a_duty_while_active: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && (rsp_tdata_ff[7:0] != '0) |-> rsp_tdata_ff[8])
      else $error("nonzero duty outside a refresh");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      go && res_done |=> phase_ff == PH_IDLE)
      else $error("refresh still running after its last slot");

   a_start_enters_pulse: assert property (@(posedge clock) disable iff (reset)
      go && (kind_ff == REQ_START) && res_ok |=> phase_ff == PH_RST_START)
      else $error("accepted start did not open the reset pulse");

   a_single_mem_op: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en || cmd.fill_en |-> go && (state_ff == ST_EXEC))
      else $error("pixel store written outside a committing step");

endmodule

`default_nettype wire

// ===== dv/rlss_frame_checker.sv =====
module rlss_frame_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   // led_index[5:0], red[13:6], green[21:14], blue[29:22], zero fill
   input  wire logic [rlss_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  wire logic [rlss_pkg::REQ_TYPE_W-1:0]  req_tuser,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // duty[7:0], line_active[8], ok[9], zero fill
   input  wire logic [rlss_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                             rsp_tlast,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic                             csr_pready,
   input  wire logic [rlss_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [rlss_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output int                                    errors,
   output int                                    pending,
   output int                                    frames
);
   timeunit 1ns;
   timeprecision 1ps;
   import rlss_pkg::*;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              active;
      logic              ok;
      logic              done;
   } slot_type;

   // Shadow of the strip driver: pixel store, refresh position, registers.
   logic [PIX_W-1:0] pixels [MAX_LEDS_DEF];
   phase_type        line_phase;
   int unsigned      slot_cnt;
   int unsigned      pix_ptr;
   int unsigned      bit_ptr;
   cfg_type          cfg;
   slot_type         expected_slots [$];

   function automatic int unsigned lit_leds();
      if (cfg.led_count == 0) return 1;
      if (cfg.led_count > MAX_LEDS_DEF) return MAX_LEDS_DEF;
      return cfg.led_count;
   endfunction

   // One slot of the closing latch pulse; true on its last slot.
   function automatic logic close_slot(int unsigned n_rst);
      slot_cnt = (slot_cnt + 1) & 8'hff;
      if (slot_cnt >= n_rst) begin
         line_phase = PH_IDLE;
         slot_cnt   = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic slot_type predict_slot(req_kind_type kind,
                                             logic [IDX_FIELD_W-1:0] idx,
                                             logic [COLOR_W-1:0] r,
                                             logic [COLOR_W-1:0] g,
                                             logic [COLOR_W-1:0] b);
      slot_type    res;
      int unsigned n_led;
      int unsigned n_rst;
      int unsigned pos;
      logic        bitv;
      res   = '0;
      res.ok = 1'b1;
      n_led = lit_leds();
      n_rst = (cfg.reset_slots == 0) ? 1 : cfg.reset_slots;
      case (kind)
         REQ_WRITE: begin
            if (idx < n_led) pixels[idx] = {g, r, b};
            else res.ok = 1'b0;
            res.active = (line_phase != PH_IDLE);
         end
         REQ_FILL: begin
            for (int i = 0; i < MAX_LEDS_DEF; i++) pixels[i] = {g, r, b};
            res.active = (line_phase != PH_IDLE);
         end
         REQ_START: begin
            if (line_phase != PH_IDLE) begin
               res.ok = 1'b0;
            end else begin
               line_phase = PH_RST_START;
               slot_cnt   = 0;
               pix_ptr    = 0;
               bit_ptr    = 0;
            end
            res.active = (line_phase != PH_IDLE);
         end
         default: begin
            // A tick reports the phase it was sent in.
            res.active = (line_phase != PH_IDLE);
            case (line_phase)
               PH_RST_START: begin
                  slot_cnt = (slot_cnt + 1) & 8'hff;
                  if (slot_cnt >= n_rst) begin
                     line_phase = PH_DATA;
                     slot_cnt   = 0;
                     pix_ptr    = 0;
                     bit_ptr    = 0;
                  end
               end
               PH_DATA: begin
                  if (pix_ptr >= n_led) begin
                     // The count was lowered below the pixel in flight.
                     line_phase = PH_RST_END;
                     slot_cnt   = 0;
                     res.done   = close_slot(n_rst);
                  end else begin
                     pos  = BPP_DEF - 1 - bit_ptr;
                     bitv = 1'b0;
                     if (pos >= BPP_DEF - PIX_W)
                        bitv = pixels[pix_ptr][pos - (BPP_DEF - PIX_W)];
                     res.duty = bitv ? cfg.one_duty : cfg.zero_duty;
                     bit_ptr++;
                     if (bit_ptr >= BPP_DEF) begin
                        bit_ptr = 0;
                        pix_ptr++;
                        if (pix_ptr >= n_led) begin
                           line_phase = PH_RST_END;
                           slot_cnt   = 0;
                        end
                     end
                  end
               end
               PH_RST_END: res.done = close_slot(n_rst);
               default: ;
            endcase
         end
      endcase
      return res;
   endfunction

   task automatic compare_field(string name, int unsigned want, int unsigned got,
                                inout int unsigned bad);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         bad++;
      end
   endtask

   always @(posedge clock) begin
      slot_type    want;
      slot_type    got;
      int unsigned bad;
      bad = 0;
      if (reset) begin
         for (int i = 0; i < MAX_LEDS_DEF; i++) pixels[i] = '0;
         line_phase          = PH_IDLE;
         slot_cnt            = 0;
         pix_ptr             = 0;
         bit_ptr             = 0;
         cfg.led_count       = LED_COUNT_RST;
         cfg.one_duty        = ONE_DUTY_RST;
         cfg.zero_duty       = ZERO_DUTY_RST;
         cfg.reset_slots     = RESET_SLOTS_RST;
         expected_slots.delete();
         errors <= 0;
         frames <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.duty   = rsp_tdata[7:0];
            got.active = rsp_tdata[8];
            got.ok     = rsp_tdata[9];
            got.done   = rsp_tlast;
            if (rsp_tlast) frames <= frames + 1;
            if (expected_slots.size() == 0) begin
               $display({"%0t: unexpected result, expected none, ",
                         "actual duty %0d active %0b ok %0b done %0b"},
                        $time, got.duty, got.active, got.ok, got.done);
               bad++;
            end else begin
               want = expected_slots.pop_front();
               compare_field("duty", want.duty, got.duty, bad);
               compare_field("line_active", want.active, got.active, bad);
               compare_field("ok", want.ok, got.ok, bad);
               compare_field("frame_done", want.done, got.done, bad);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_slots.push_back(predict_slot(req_kind_type'(req_tuser), req_tdata[5:0],
                                                  req_tdata[13:6], req_tdata[21:14],
                                                  req_tdata[29:22]));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_LED_COUNT:   cfg.led_count   = csr_pwdata[LED_COUNT_W-1:0];
               REG_ONE_DUTY:    cfg.one_duty    = csr_pwdata[DUTY_W-1:0];
               REG_ZERO_DUTY:   cfg.zero_duty   = csr_pwdata[DUTY_W-1:0];
               REG_RESET_SLOTS: cfg.reset_slots = csr_pwdata[SLOT_W-1:0];
               default: ;
            endcase
         end
      end
      if (bad != 0) errors <= errors + bad;
      pending <= expected_slots.size();
   end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rlss_pkg::*;

   localparam int unsigned TOTAL_ITEMS   = 1450;
   localparam int unsigned QUIET_TAIL    = 200;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned STALL_LIMIT   = 2000;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [REQ_TYPE_W-1:0]  req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int                     errors;
   int                     pending;
   int                     frames;

   logic                   rx_idle_on    = 1'b1;
   logic                   long_hold_req = 1'b0;
   logic                   long_hold_done = 1'b0;
   bit                     tx_idle_on    = 1'b1;
   int unsigned            tx_gap_pct    = 10;
   int unsigned            quiet_cycles  = 0;

   logic [LED_COUNT_W-1:0] cur_count = LED_COUNT_RST;
   int unsigned            sent, n_write, n_fill, n_start, n_tick, settings;

   rgb_led_strip_serializer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rlss_frame_checker frame_chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .errors      (errors),
      .pending     (pending),
      .frames      (frames)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("FAIL rgb_led_strip_serializer");
      $finish;
   end

   // Result side: random ready bursts and stalls, plus one long hold-off
   // that lets the block back up into its input.
   initial begin
      forever begin
         if (long_hold_req && !long_hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   function automatic int unsigned lit_leds();
      if (cur_count == 0) return 1;
      if (cur_count > MAX_LEDS_DEF) return MAX_LEDS_DEF;
      return cur_count;
   endfunction

   // Leaves tvalid high on return so that a following item keeps the bus busy.
   task automatic send_req(req_kind_type kind, logic [IDX_FIELD_W-1:0] idx,
                           logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                           logic [COLOR_W-1:0] b);
      if (tx_idle_on && $urandom_range(0, 99) < tx_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, b, g, r, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      case (kind)
         REQ_WRITE: n_write++;
         REQ_FILL:  n_fill++;
         REQ_START: n_start++;
         default:   n_tick++;
      endcase
   endtask

   // Any request kind with random index and color fields.
   task automatic send_random(req_kind_type kind);
      logic [IDX_FIELD_W-1:0] idx;
      logic [COLOR_W-1:0]     r, g, b;
      idx = IDX_FIELD_W'($urandom);
      r   = COLOR_W'($urandom);
      g   = COLOR_W'($urandom);
      b   = COLOR_W'($urandom);
      send_req(kind, idx, r, g, b);
   endtask

   // Write, fill or (with kinds of three) start, with the index mostly in range.
   task automatic send_mixed(int unsigned kinds);
      logic [IDX_FIELD_W-1:0] idx;
      logic [COLOR_W-1:0]     r, g, b;
      int unsigned            pick;
      pick = $urandom_range(0, kinds - 1);
      if ($urandom_range(0, 99) < 75) idx = IDX_FIELD_W'($urandom_range(0, lit_leds() - 1));
      else idx = IDX_FIELD_W'($urandom_range(0, MAX_LEDS_DEF - 1));
      r = COLOR_W'($urandom);
      g = COLOR_W'($urandom);
      b = COLOR_W'($urandom);
      case (pick)
         0:       send_req(REQ_WRITE, idx, r, g, b);
         1:       send_req(REQ_FILL, idx, r, g, b);
         default: send_req(REQ_START, idx, r, g, b);
      endcase
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Back-to-back writes keep psel high; only penable drops for each setup.
   task automatic csr_write(reg_index_type which, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic program_regs(logic [LED_COUNT_W-1:0] count, logic [DUTY_W-1:0] one_val,
                               logic [DUTY_W-1:0] zero_val, logic [SLOT_W-1:0] slots);
      csr_write(REG_LED_COUNT, CSR_DATA_W'(count));
      csr_write(REG_ONE_DUTY, CSR_DATA_W'(one_val));
      csr_write(REG_ZERO_DUTY, CSR_DATA_W'(zero_val));
      csr_write(REG_RESET_SLOTS, CSR_DATA_W'(slots));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_count = count;
      settings++;
   endtask

   initial begin
      int unsigned            phase_no;
      int unsigned            n_ticks;
      int unsigned            eff_rst;
      logic [SLOT_W-1:0]      cur_slots;
      logic [LED_COUNT_W-1:0] new_count;
      logic [DUTY_W-1:0]      new_one;
      logic [DUTY_W-1:0]      new_zero;
      logic [SLOT_W-1:0]      new_slots;

      cur_slots = RESET_SLOTS_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Idle tick and the top pixel at the default count.
      send_req(REQ_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
      send_req(REQ_WRITE, 6'd63, 8'hff, 8'h00, 8'hff);
      wait_idle();
      // A count above the store size acts as the store size.
      program_regs(7'd127, 8'd255, 8'd0, 8'd1);
      send_req(REQ_WRITE, 6'd63, 8'h00, 8'hff, 8'h00);
      wait_idle();
      program_regs(7'd1, 8'd255, 8'd0, 8'd1);
      cur_slots = 8'd1;
      send_req(REQ_WRITE, 6'd1, 8'h12, 8'h34, 8'h56);
      send_req(REQ_WRITE, 6'd63, 8'hff, 8'hff, 8'hff);
      send_req(REQ_FILL, 6'd0, 8'hff, 8'hff, 8'hff);
      send_req(REQ_FILL, 6'd0, 8'h00, 8'h00, 8'h00);
      send_req(REQ_WRITE, 6'd0, 8'hff, 8'h00, 8'haa);
      send_req(REQ_START, 6'd0, 8'h00, 8'h00, 8'h00);
      send_req(REQ_START, 6'd0, 8'h00, 8'h00, 8'h00);
      repeat (5) send_req(REQ_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
      // Rewriting the pixel in flight changes the bits still to be sent.
      send_req(REQ_WRITE, 6'd0, 8'h00, 8'hff, 8'h00);
      repeat (4) send_req(REQ_TICK, 6'h3f, 8'hff, 8'hff, 8'hff);
      wait_idle();
      // Zero count and zero pulse length, applied in the middle of a refresh.
      program_regs(7'd0, 8'd0, 8'd255, 8'd0);
      cur_slots = 8'd0;

      phase_no = 0;
      while (sent < TOTAL_ITEMS) begin
         phase_no++;
         if (sent > TOTAL_ITEMS - QUIET_TAIL) begin
            tx_idle_on = 1'b0;
            rx_idle_on <= 1'b0;
         end
         if ($urandom_range(0, 99) < 70) begin
            case ($urandom_range(0, 9))
               0:       new_count = 7'd0;
               1:       new_count = LED_COUNT_W'($urandom_range(4, 8));
               default: new_count = LED_COUNT_W'($urandom_range(1, 3));
            endcase
            new_one  = DUTY_W'($urandom);
            new_zero = DUTY_W'($urandom);
            if ($urandom_range(0, 9) == 0) new_one = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            if ($urandom_range(0, 9) == 0) new_zero = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            case ($urandom_range(0, 19))
               0, 1:    new_slots = 8'd0;
               2:       new_slots = SLOT_W'($urandom_range(200, 255));
               default: new_slots = SLOT_W'($urandom_range(1, 4));
            endcase
            wait_idle();
            program_regs(new_count, new_one, new_zero, new_slots);
            cur_slots = new_slots;
         end
         case ($urandom_range(0, 2))
            0:       tx_gap_pct = 0;
            1:       tx_gap_pct = 10;
            default: tx_gap_pct = 35;
         endcase
         if (phase_no == 4) begin
            long_hold_req <= 1'b1;
            tx_gap_pct = 0;
         end

         // Mostly a well-formed refresh: optional pixel updates, a start and
         // enough ticks to finish it, sometimes cut short, with stray requests.
         repeat ($urandom_range(0, 3)) send_mixed(2);
         send_random(REQ_START);
         eff_rst = (cur_slots == 0) ? 1 : cur_slots;
         n_ticks = 2 * eff_rst + BPP_DEF * lit_leds() + $urandom_range(0, 6);
         if ($urandom_range(0, 99) < 25) n_ticks = $urandom_range(1, n_ticks);
         if (n_ticks > 120) n_ticks = 120;
         repeat (n_ticks) begin
            if ($urandom_range(0, 99) < 8) send_mixed(3);
            else send_random(REQ_TICK);
         end
      end

      wait_idle();
      $display("Covered %0d requests (%0d writes, %0d fills, %0d starts, %0d ticks).",
               sent, n_write, n_fill, n_start, n_tick);
      $display("Used %0d register settings, saw %0d finished frames, one long output stall.",
               settings, frames);
      if (errors == 0) begin
         $display("PASS rgb_led_strip_serializer");
      end else begin
         $display("FAIL rgb_led_strip_serializer");
      end
      $finish;
   end

endmodule
